>>> sv/rtc3w_pkg.sv
// ----------------------------------------------------------------------------
// rtc3w_pkg: shared types and constants of the three-wire rtc master
// command codes, sequencer modes and register address tables
// ----------------------------------------------------------------------------
package rtc3w_pkg;

   // request opcodes
   localparam logic [1:0] OP_WRITE_TIME = 2'd0;
   localparam logic [1:0] OP_READ_TIME  = 2'd1;
   localparam logic [1:0] OP_TICK       = 2'd2;
   localparam logic [1:0] OP_NOP        = 2'd3;

   // sequencer modes
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic [4:0] GAP_TICK      = 5'd16;
   localparam logic [3:0] WRITE_LAST    = 4'd9;
   localparam logic [3:0] READ_LAST     = 4'd6;
   localparam logic [3:0] SECONDS_INDEX = 4'd5;

   localparam logic [7:0] CTRL_UNPROTECT = 8'h00;
   localparam logic [7:0] CTRL_PROTECT   = 8'h80;
   localparam logic [7:0] SECONDS_HALT   = 8'h80;
   localparam logic [7:0] SECONDS_MASK   = 8'h7F;
   localparam logic [7:0] ADDR_WR_MASK   = 8'hFE;
   localparam logic [7:0] ADDR_RD_BIT    = 8'h01;

   // one response as it sits in the output register
   typedef struct packed {
      logic       rejected;
      logic [7:0] byte_value;
      logic [2:0] byte_index;
      logic       data_drive;
      logic       data_out;
      logic       clock_pulse;
      logic       chip_enable;
      logic       byte_valid;
      logic       done_res;
   } rsp_type;

   // write-form address of each write transaction
   function automatic logic [7:0] wr_addr(input logic [3:0] t);
      case (t)
         4'd0:    wr_addr = 8'h8E;
         4'd1:    wr_addr = 8'h80;
         4'd2:    wr_addr = 8'h8C;
         4'd3:    wr_addr = 8'h88;
         4'd4:    wr_addr = 8'h86;
         4'd5:    wr_addr = 8'h84;
         4'd6:    wr_addr = 8'h82;
         4'd7:    wr_addr = 8'h80;
         4'd8:    wr_addr = 8'h8A;
         default: wr_addr = 8'h8E;
      endcase
   endfunction

   // write-form address of each read transaction, in byte index order
   function automatic logic [7:0] rd_addr(input logic [3:0] t);
      case (t)
         4'd0:    rd_addr = 8'h8C;
         4'd1:    rd_addr = 8'h88;
         4'd2:    rd_addr = 8'h86;
         4'd3:    rd_addr = 8'h84;
         4'd4:    rd_addr = 8'h82;
         4'd5:    rd_addr = 8'h80;
         default: rd_addr = 8'h8A;
      endcase
   endfunction

endpackage

>>> sv/rtc_three_wire_time_transfer.sv
// ----------------------------------------------------------------------------
// rtc_three_wire_time_transfer: tick-driven three-wire rtc master
// sequences time writes and reads over a chip-enable / clock / data bus
// ----------------------------------------------------------------------------
// Each request is a command (write time, read time), a serial tick or a no-op,
// and it yields exactly one registered response. A write-time command
// latches the seven time bytes and runs ten write transactions (unprotect,
// halt seconds, year..weekday, protect); a read-time command runs seven read
// transactions and reports each byte on its gap tick with byte_valid set in
// tuser. A transaction is 16 pulse ticks (address then data, lsb first)
// followed by one chip-enable-low gap tick; tlast marks the final gap of a
// sequence. Commands issued while a sequence runs are ignored and flagged as
// rejected. Throughput is one request per clock: the sequencer state and the
// response are both computed in one pass from the request and the current
// state, and the single output register lets a new request in whenever it is
// empty or the held response is taken in the same cycle.
module rtc_three_wire_time_transfer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // dat_in[0], year[8:1], month[16:9], date[24:17], hour[32:25],
   // minute[40:33], second[48:41], weekday[56:49], zero fill[63:57]
   input  logic [63:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // chip_enable[0], clock_pulse[1], data_out[2], data_drive[3],
   // byte_index[6:4], byte_value[14:7], rejected[15]
   output logic [15:0] rsp_tdata,
   // byte_valid[0]
   output logic        rsp_tuser,
   // done_res
   output logic        rsp_tlast
);

   // sequencer state
   logic [1:0] mode_ff, mode_in;
   logic [3:0] tidx_ff, tidx_in;
   logic [4:0] tick_ff, tick_in;
   logic [7:0] acc_ff,  acc_in;

   // latched time bytes, no reset: always written before first use
   logic [7:0] wbytes_ff [7];

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   rtc3w_pkg::rsp_type  rsp_ff, rsp_in;

   logic       accept;
   logic [1:0] op;
   logic       din;
   logic       busy;
   logic       rd;
   logic [3:0] last_t;
   logic [3:0] t;
   logic [2:0] wb_idx;
   logic [7:0] addr;
   logic [7:0] wdata;
   logic [7:0] rvalue;

   // a new request enters whenever the output slot is free or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op         = req_tuser;
   assign din        = req_tdata[0];

   // mode 3 cannot be reached and acts as idle
   assign busy   = (mode_ff == rtc3w_pkg::MODE_WRITE) || (mode_ff == rtc3w_pkg::MODE_READ);
   assign rd     = (mode_ff == rtc3w_pkg::MODE_READ);
   assign last_t = rd ? rtc3w_pkg::READ_LAST : rtc3w_pkg::WRITE_LAST;
   assign t      = (tidx_ff > last_t) ? last_t : tidx_ff;

   // address byte on the wire: bit0 set for reads
   assign addr = rd ? (rtc3w_pkg::rd_addr(t) | rtc3w_pkg::ADDR_RD_BIT)
                    : (rtc3w_pkg::wr_addr(t) & rtc3w_pkg::ADDR_WR_MASK);

   // data byte of a write transaction
   assign wb_idx = 3'(t - 4'd2);
   always_comb begin
      case (t)
         4'd0:                         wdata = rtc3w_pkg::CTRL_UNPROTECT;
         4'd1:                         wdata = rtc3w_pkg::SECONDS_HALT;
         4'd2, 4'd3, 4'd4, 4'd5,
         4'd6, 4'd7, 4'd8:             wdata = wbytes_ff[wb_idx];
         default:                      wdata = rtc3w_pkg::CTRL_PROTECT;
      endcase
   end

   // seconds come back with the halt flag stripped
   assign rvalue = (t == rtc3w_pkg::SECONDS_INDEX) ? (acc_ff & rtc3w_pkg::SECONDS_MASK)
                                                   : acc_ff;

   always_comb begin
      mode_in      = mode_ff;
      tidx_in      = tidx_ff;
      tick_in      = tick_ff;
      acc_in       = acc_ff;
      rsp_in       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (accept) begin
         rsp_valid_in = 1'b1;
         unique case (op) inside
            rtc3w_pkg::OP_WRITE_TIME, rtc3w_pkg::OP_READ_TIME: begin
               if (busy) begin
                  rsp_in.rejected = 1'b1;
               end else begin
                  mode_in = (op == rtc3w_pkg::OP_WRITE_TIME) ? rtc3w_pkg::MODE_WRITE
                                                             : rtc3w_pkg::MODE_READ;
                  tidx_in = '0;
                  tick_in = '0;
                  acc_in  = '0;
               end
            end
            rtc3w_pkg::OP_TICK: begin
               if (busy) begin
                  if (tick_ff < rtc3w_pkg::GAP_TICK) begin
                     // pulse tick: address bits, then data bits
                     rsp_in.chip_enable = 1'b1;
                     rsp_in.clock_pulse = 1'b1;
                     if (!tick_ff[3]) begin
                        rsp_in.data_out   = addr[tick_ff[2:0]];
                        rsp_in.data_drive = 1'b1;
                     end else if (!rd) begin
                        rsp_in.data_out   = wdata[tick_ff[2:0]];
                        rsp_in.data_drive = 1'b1;
                     end else begin
                        acc_in = {din, acc_ff[7:1]};
                     end
                     tick_in = tick_ff + 5'd1;
                  end else begin
                     // gap tick: chip enable low, hand over a read byte
                     if (rd) begin
                        rsp_in.byte_valid = 1'b1;
                        rsp_in.byte_index = t[2:0];
                        rsp_in.byte_value = rvalue;
                        acc_in            = '0;
                     end
                     tick_in = '0;
                     if (t == last_t) begin
                        rsp_in.done_res = 1'b1;
                        mode_in         = rtc3w_pkg::MODE_IDLE;
                        tidx_in         = '0;
                     end else begin
                        tidx_in = t + 4'd1;
                     end
                  end
               end
            end
            default: begin
               // no-op
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= rtc3w_pkg::MODE_IDLE;
         tidx_ff      <= '0;
         tick_ff      <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         tidx_ff      <= tidx_in;
         tick_ff      <= tick_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
      if (accept && (op == rtc3w_pkg::OP_WRITE_TIME) && !busy) begin
         wbytes_ff[0] <= req_tdata[8:1];
         wbytes_ff[1] <= req_tdata[16:9];
         wbytes_ff[2] <= req_tdata[24:17];
         wbytes_ff[3] <= req_tdata[32:25];
         wbytes_ff[4] <= req_tdata[40:33];
         wbytes_ff[5] <= req_tdata[48:41];
         wbytes_ff[6] <= req_tdata[56:49];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.rejected, rsp_ff.byte_value, rsp_ff.byte_index,
                        rsp_ff.data_drive, rsp_ff.data_out, rsp_ff.clock_pulse,
                        rsp_ff.chip_enable};
   assign rsp_tuser  = rsp_ff.byte_valid;
   assign rsp_tlast  = rsp_ff.done_res;

   // tick counter never passes the gap slot
   a_tick_range: assert property (@(posedge clock) disable iff (reset)
      tick_ff <= rtc3w_pkg::GAP_TICK)
      else $error("tick counter out of range");

   // an idle sequencer holds no transaction position
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == rtc3w_pkg::MODE_IDLE) |-> (tidx_ff == '0 && tick_ff == '0))
      else $error("idle sequencer with stale position");

   // end of sequence is always a gap tick with the bus released
   a_done_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[3:0] == 4'd0))
      else $error("done flagged outside a gap tick");

   // a reported byte carries a legal index
   a_byte_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[6:4] <= 3'd6))
      else $error("read byte index out of range");

   // a finished sequence leaves the block idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_in.done_res) |=> (mode_ff == rtc3w_pkg::MODE_IDLE))
      else $error("sequencer still busy after done");

endmodule

>>> verif/rtc_time_transfer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_time_transfer_checker: bus slot predictor and response scoreboard
// mirrors the sequencer on every accepted request, compares every response
// ----------------------------------------------------------------------------
module rtc_time_transfer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          pending_count
);

   // write-form register addresses, transaction 0 in the low byte
   localparam logic [79:0] WRITE_ADDRS =
      {8'h8E, 8'h8A, 8'h80, 8'h82, 8'h84, 8'h86, 8'h88, 8'h8C, 8'h80, 8'h8E};
   localparam logic [55:0] READ_ADDRS =
      {8'h8A, 8'h80, 8'h82, 8'h84, 8'h86, 8'h88, 8'h8C};

   // mirrored sequencer state
   logic [1:0]  seq_mode;
   logic [3:0]  txn;
   logic [4:0]  slot;
   logic [7:0]  shift_in;
   logic [55:0] time_latch;

   rtc3w_pkg::rsp_type bus_slots_due[$];
   int                 errors;

   // data byte of write transaction t
   function automatic logic [7:0] write_byte(input logic [3:0] t);
      if (t == 4'd0) return rtc3w_pkg::CTRL_UNPROTECT;
      if (t == 4'd1) return rtc3w_pkg::SECONDS_HALT;
      if (t <= 4'd8) return time_latch[8 * (t - 4'd2) +: 8];
      return rtc3w_pkg::CTRL_PROTECT;
   endfunction

   // one request in, one bus slot out
   function automatic rtc3w_pkg::rsp_type next_bus_slot(input logic [1:0] op,
                                                        input logic din,
                                                        input logic [55:0] tbytes);
      rtc3w_pkg::rsp_type r;
      logic       busy;
      logic       rd;
      logic [3:0] last;
      logic [3:0] t;
      logic [7:0] a;
      logic [7:0] v;
      r = '0;
      busy = (seq_mode == rtc3w_pkg::MODE_WRITE) || (seq_mode == rtc3w_pkg::MODE_READ);
      if (op == rtc3w_pkg::OP_WRITE_TIME || op == rtc3w_pkg::OP_READ_TIME) begin
         if (busy) begin
            r.rejected = 1'b1;
         end else begin
            if (op == rtc3w_pkg::OP_WRITE_TIME) begin
               time_latch = tbytes;
               seq_mode   = rtc3w_pkg::MODE_WRITE;
            end else begin
               seq_mode = rtc3w_pkg::MODE_READ;
            end
            txn      = '0;
            slot     = '0;
            shift_in = '0;
         end
      end else if (op == rtc3w_pkg::OP_TICK && busy) begin
         rd   = (seq_mode == rtc3w_pkg::MODE_READ);
         last = rd ? rtc3w_pkg::READ_LAST : rtc3w_pkg::WRITE_LAST;
         t    = (txn > last) ? last : txn;
         if (slot < rtc3w_pkg::GAP_TICK) begin
            r.chip_enable = 1'b1;
            r.clock_pulse = 1'b1;
            if (slot < 5'd8) begin
               a = rd ? (READ_ADDRS[8 * t +: 8] | rtc3w_pkg::ADDR_RD_BIT)
                      : (WRITE_ADDRS[8 * t +: 8] & rtc3w_pkg::ADDR_WR_MASK);
               r.data_out   = a[slot[2:0]];
               r.data_drive = 1'b1;
            end else if (!rd) begin
               v = write_byte(t);
               r.data_out   = v[slot[2:0]];
               r.data_drive = 1'b1;
            end else begin
               shift_in = {din, shift_in[7:1]};
            end
            slot = slot + 5'd1;
         end else begin
            if (rd) begin
               v = shift_in;
               if (t == rtc3w_pkg::SECONDS_INDEX) v = v & rtc3w_pkg::SECONDS_MASK;
               r.byte_valid = 1'b1;
               r.byte_index = t[2:0];
               r.byte_value = v;
               shift_in     = '0;
            end
            slot = '0;
            if (t == last) begin
               r.done_res = 1'b1;
               seq_mode   = rtc3w_pkg::MODE_IDLE;
               txn        = '0;
            end else begin
               txn = t + 4'd1;
            end
         end
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         errors = errors + 1;
         if (errors <= 10)
            $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rtc3w_pkg::rsp_type want;
      if (reset) begin
         seq_mode   = rtc3w_pkg::MODE_IDLE;
         txn        = '0;
         slot       = '0;
         shift_in   = '0;
         time_latch = '0;
         bus_slots_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (bus_slots_due.size() == 0) begin
               errors = errors + 1;
               if (errors <= 10)
                  $display("%0t: response with nothing outstanding, tdata %0h",
                           $realtime, rsp_tdata);
            end else begin
               want = bus_slots_due.pop_front();
               check_field("chip_enable", 8'(want.chip_enable), 8'(rsp_tdata[0]));
               check_field("clock_pulse", 8'(want.clock_pulse), 8'(rsp_tdata[1]));
               check_field("data_out",    8'(want.data_out),    8'(rsp_tdata[2]));
               check_field("data_drive",  8'(want.data_drive),  8'(rsp_tdata[3]));
               check_field("byte_index",  8'(want.byte_index),  8'(rsp_tdata[6:4]));
               check_field("byte_value",  want.byte_value,      rsp_tdata[14:7]);
               check_field("rejected",    8'(want.rejected),    8'(rsp_tdata[15]));
               check_field("byte_valid",  8'(want.byte_valid),  8'(rsp_tuser));
               check_field("done_res",    8'(want.done_res),    8'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready)
            bus_slots_due.push_back(next_bus_slot(req_tuser, req_tdata[0],
                                                  req_tdata[56:1]));
      end
      mismatch_count <= errors;
      pending_count  <= bus_slots_due.size();
   end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the three-wire rtc master
// drives commands, serial ticks and no-ops under shifting back-pressure
// ----------------------------------------------------------------------------
// A short directed opening covers idle ticks, the no-op opcode, commands
// rejected mid-sequence, all-ones and all-zeros time bytes and read data that
// exercises the seconds mask. The random part is mostly complete write-time
// and read-time sequences with random bytes and line levels, sprinkled with
// stray commands and no-ops, plus idle noise. It runs in three phases of
// sender and receiver idling. The checker beside the block does all the
// prediction and comparison; this module only counts its failures.
module testbench;

   localparam int WRITE_SEQ_TICKS = 170;   // ten transactions of 17 slots
   localparam int READ_SEQ_TICKS  = 119;   // seven transactions of 17 slots
   localparam int PHASE_ITEMS     = 320;
   localparam int CYCLE_LIMIT     = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = rtc3w_pkg::OP_NOP;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   int mismatch_count;
   int pending_count;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int items_sent  = 0;
   int cycle_count = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   rtc_three_wire_time_transfer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   rtc_time_transfer_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // one request; tvalid stays high on return so back-to-back requests
   // never lower and raise it in the same step
   task automatic push_request(input logic [1:0] op, input logic [63:0] data,
                               input bit counted);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (counted) items_sent++;
   endtask

   // request fields: dat_in in bit 0, seven time bytes above, zero fill on top
   function automatic logic [63:0] pack_request(input logic din,
                                                input logic [55:0] time_bytes);
      return {7'b0, time_bytes, din};
   endfunction

   function automatic logic [55:0] random_bytes();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[55:0];
   endfunction

   // serial ticks; din_mode 0 low, 1 high, 2 random line level
   task automatic run_ticks(input int count, input int din_mode);
      logic din;
      for (int i = 0; i < count; i++) begin
         din = (din_mode == 2) ? 1'($urandom_range(1)) : 1'(din_mode);
         push_request(rtc3w_pkg::OP_TICK, pack_request(din, random_bytes()), 1'b1);
      end
   endtask

   // command that lands while a sequence runs: rejected or a no-op
   task automatic stray_request();
      logic [1:0] op;
      case ($urandom_range(2))
         0:       op = rtc3w_pkg::OP_WRITE_TIME;
         1:       op = rtc3w_pkg::OP_READ_TIME;
         default: op = rtc3w_pkg::OP_NOP;
      endcase
      push_request(op, pack_request(1'($urandom_range(1)), random_bytes()), 1'b1);
   endtask

   // well-formed sequence from idle, with the odd stray command mixed in
   task automatic run_sequence(input logic [1:0] op);
      int ticks;
      ticks = (op == rtc3w_pkg::OP_WRITE_TIME) ? WRITE_SEQ_TICKS : READ_SEQ_TICKS;
      push_request(op, pack_request(1'($urandom_range(1)), random_bytes()), 1'b1);
      for (int i = 0; i < ticks; i++) begin
         if ($urandom_range(99) < 4) stray_request();
         run_ticks(1, 2);
      end
   endtask

   // ticks and no-ops while idle; the block ignores them
   task automatic idle_noise();
      int n;
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++)
         push_request($urandom_range(1) ? rtc3w_pkg::OP_TICK : rtc3w_pkg::OP_NOP,
                      pack_request(1'($urandom_range(1)), random_bytes()), 1'b0);
   endtask

   // hold off until every outstanding response has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int target);
      int pick;
      items_sent = 0;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 45)      run_sequence(rtc3w_pkg::OP_WRITE_TIME);
         else if (pick < 85) run_sequence(rtc3w_pkg::OP_READ_TIME);
         else                idle_noise();
      end
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: idle tick and no-op opcode do nothing
      push_request(rtc3w_pkg::OP_TICK, pack_request(1'b1, '1), 1'b1);
      push_request(rtc3w_pkg::OP_NOP, pack_request(1'b1, '1), 1'b1);
      // write with all-ones bytes; commands mid-sequence are rejected
      push_request(rtc3w_pkg::OP_WRITE_TIME, pack_request(1'b1, '1), 1'b1);
      run_ticks(3, 1);
      push_request(rtc3w_pkg::OP_READ_TIME, pack_request(1'b0, '0), 1'b1);
      push_request(rtc3w_pkg::OP_WRITE_TIME, pack_request(1'b0, '0), 1'b1);
      push_request(rtc3w_pkg::OP_NOP, pack_request(1'b0, '0), 1'b1);
      run_ticks(WRITE_SEQ_TICKS - 3, 0);
      // write with all-zeros bytes
      push_request(rtc3w_pkg::OP_WRITE_TIME, pack_request(1'b0, '0), 1'b1);
      run_ticks(WRITE_SEQ_TICKS, 1);
      // read of all ones shows the seconds mask, then a read of all zeros
      push_request(rtc3w_pkg::OP_READ_TIME, pack_request(1'b1, '1), 1'b1);
      run_ticks(READ_SEQ_TICKS, 1);
      push_request(rtc3w_pkg::OP_READ_TIME, pack_request(1'b0, '1), 1'b1);
      run_ticks(READ_SEQ_TICKS, 0);
      // sender pauses until everything is back
      drain();

      // busy sender, stalling receiver
      tx_idle_pct = 14;
      rx_idle_pct = 87;
      random_phase(PHASE_ITEMS);
      // the other way round
      tx_idle_pct = 87;
      rx_idle_pct = 14;
      random_phase(PHASE_ITEMS);
      // full rate
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_phase(PHASE_ITEMS);

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/rtc3w_pkg.sv
sv/rtc_three_wire_time_transfer.sv
verif/rtc_time_transfer_checker.sv
verif/testbench.sv
